// ===== src/cbrs_pkg.sv =====
package cbrs_pkg;

	localparam int COORD_BITS     = 12;
	localparam int DELTA_BITS     = COORD_BITS + 1;
	localparam int ERR_BITS       = COORD_BITS + 2;
	localparam int POS_BITS       = COORD_BITS + 2;
	localparam int CFG_INDEX_BITS = 2;

	typedef logic [COORD_BITS-1:0]        coord_t;
	typedef logic signed [DELTA_BITS-1:0] delta_t;
	typedef logic signed [ERR_BITS-1:0]   err_t;
	typedef logic signed [POS_BITS-1:0]   pos_t;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_LEFT   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_TOP    = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_RIGHT  = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_BOTTOM = 2'd3;

	typedef struct packed {
		coord_t left;
		coord_t top;
		coord_t right;
		coord_t bottom;
	} clip_t;

	typedef struct packed {
		logic   axis_is_y;
		coord_t major_delta;
		coord_t minor_delta;
		logic   major_negative;
		logic   minor_negative;
		err_t   error_term;
		delta_t major_offset;
		delta_t minor_offset;
		coord_t origin_x;
		coord_t origin_y;
		coord_t step_limit;
		logic   active;
	} ray_state_t;

	typedef struct packed {
		logic   pixel_valid;
		coord_t pixel_x;
		coord_t pixel_y;
		logic   run_done;
		logic   clipped;
		coord_t steps_taken;
	} result_t;

	typedef struct packed {
		logic   command;
		coord_t start_x;
		coord_t start_y;
		delta_t delta_x;
		delta_t delta_y;
		coord_t step_count;
	} request_t;

endpackage

// ===== src/clipped_bresenham_ray_stepper.sv =====
// Channel  Handshake            Payload
// in       in_valid, in_stall   command, start_x, start_y, delta_x, delta_y, step_count
// out      out_valid, out_stall pixel_valid, pixel_x, pixel_y, run_done, clipped, steps_taken
// config   cfg_we               cfg_index, cfg_data
//
// The step logic sits between the ray state registers and the output
// register, so one item is accepted per clock unless in_stall is raised.
// A step item shows its result in the cycle after it is accepted; a load item
// gives no result. Reset clears the ray state and restores the full clip
// rectangle. While a result waits under out_stall, in_stall is raised.
module clipped_bresenham_ray_stepper (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 command,
	input  logic [cbrs_pkg::COORD_BITS-1:0]      start_x,
	input  logic [cbrs_pkg::COORD_BITS-1:0]      start_y,
	input  logic signed [cbrs_pkg::DELTA_BITS-1:0] delta_x,
	input  logic signed [cbrs_pkg::DELTA_BITS-1:0] delta_y,
	input  logic [cbrs_pkg::COORD_BITS-1:0]      step_count,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 pixel_valid,
	output logic [cbrs_pkg::COORD_BITS-1:0]      pixel_x,
	output logic [cbrs_pkg::COORD_BITS-1:0]      pixel_y,
	output logic                                 run_done,
	output logic                                 clipped,
	output logic [cbrs_pkg::COORD_BITS-1:0]      steps_taken,
	input  logic                                 cfg_we,
	input  logic [cbrs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [cbrs_pkg::COORD_BITS-1:0]      cfg_data
);

	cbrs_pkg::ray_state_t state_q, next_state;
	cbrs_pkg::clip_t      clip_q;
	cbrs_pkg::result_t    result, res_q;
	cbrs_pkg::request_t   req;
	logic                 has_result;
	logic                 out_valid_q;
	logic                 accept;

	assign req.command    = command;
	assign req.start_x    = start_x;
	assign req.start_y    = start_y;
	assign req.delta_x    = delta_x;
	assign req.delta_y    = delta_y;
	assign req.step_count = step_count;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	cbrs_core u_core (
		.req        (req),
		.state      (state_q),
		.clip       (clip_q),
		.next_state (next_state),
		.result     (result),
		.has_result (has_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= '0;
			clip_q.left   <= '0;
			clip_q.top    <= '0;
			clip_q.right  <= '1;
			clip_q.bottom <= '1;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cbrs_pkg::REG_CLIP_LEFT:   clip_q.left   <= cfg_data;
					cbrs_pkg::REG_CLIP_TOP:    clip_q.top    <= cfg_data;
					cbrs_pkg::REG_CLIP_RIGHT:  clip_q.right  <= cfg_data;
					cbrs_pkg::REG_CLIP_BOTTOM: clip_q.bottom <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				state_q <= next_state;
			end
			if (accept && has_result) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && has_result) begin
			res_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_valid = res_q.pixel_valid;
	assign pixel_x     = res_q.pixel_x;
	assign pixel_y     = res_q.pixel_y;
	assign run_done    = res_q.run_done;
	assign clipped     = res_q.clipped;
	assign steps_taken = res_q.steps_taken;

endmodule

// ===== src/cbrs_core.sv =====
module cbrs_core (
	input  cbrs_pkg::request_t   req,
	input  cbrs_pkg::ray_state_t state,
	input  cbrs_pkg::clip_t      clip,
	output cbrs_pkg::ray_state_t next_state,
	output cbrs_pkg::result_t    result,
	output logic                 has_result
);

	// Magnitude of a signed delta, with the most negative code saturated.
	function automatic cbrs_pkg::coord_t sat_mag(input cbrs_pkg::delta_t d);
		logic [cbrs_pkg::DELTA_BITS-1:0] a;
		a = d[cbrs_pkg::DELTA_BITS-1] ? cbrs_pkg::DELTA_BITS'(-d) : cbrs_pkg::DELTA_BITS'(d);
		if (a[cbrs_pkg::COORD_BITS]) begin
			return '1;
		end
		return a[cbrs_pkg::COORD_BITS-1:0];
	endfunction

	cbrs_pkg::coord_t ax, ay, major_sel, steps, steps_next;
	cbrs_pkg::delta_t d_major, d_minor, steps_full, off_x, off_y, one;
	logic             y_major;
	cbrs_pkg::pos_t   cx, cy;
	cbrs_pkg::err_t   err_sub;
	logic             outside;

	assign one = cbrs_pkg::delta_t'(1);

	always_comb begin
		ax        = sat_mag(req.delta_x);
		ay        = sat_mag(req.delta_y);
		y_major   = ay > ax;
		major_sel = y_major ? ay : ax;
		d_major   = y_major ? req.delta_y : req.delta_x;
		d_minor   = y_major ? req.delta_x : req.delta_y;

		steps_full = state.major_offset[cbrs_pkg::DELTA_BITS-1] ?
			-state.major_offset : state.major_offset;
		steps      = steps_full[cbrs_pkg::COORD_BITS-1:0];
		steps_next = steps + cbrs_pkg::COORD_BITS'(1);

		off_x = state.axis_is_y ? state.minor_offset : state.major_offset;
		off_y = state.axis_is_y ? state.major_offset : state.minor_offset;
		cx    = cbrs_pkg::pos_t'({2'b00, state.origin_x}) + cbrs_pkg::pos_t'(off_x);
		cy    = cbrs_pkg::pos_t'({2'b00, state.origin_y}) + cbrs_pkg::pos_t'(off_y);
		outside = (cx < 0) || (cy < 0) ||
			(cx < cbrs_pkg::pos_t'({2'b00, clip.left})) ||
			(cx > cbrs_pkg::pos_t'({2'b00, clip.right})) ||
			(cy < cbrs_pkg::pos_t'({2'b00, clip.top})) ||
			(cy > cbrs_pkg::pos_t'({2'b00, clip.bottom}));
		err_sub = state.error_term - cbrs_pkg::err_t'({2'b00, state.minor_delta});

		next_state = state;
		result     = '0;
		has_result = 1'b0;

		if (req.command == cbrs_pkg::CMD_LOAD) begin
			next_state.axis_is_y      = y_major;
			next_state.major_delta    = major_sel;
			next_state.minor_delta    = y_major ? ax : ay;
			// A zero delta counts as negative.
			next_state.major_negative = d_major[cbrs_pkg::DELTA_BITS-1] || (d_major == '0);
			next_state.minor_negative = d_minor[cbrs_pkg::DELTA_BITS-1] || (d_minor == '0);
			next_state.error_term     = cbrs_pkg::err_t'({2'b00, major_sel >> 1});
			next_state.major_offset   = '0;
			next_state.minor_offset   = '0;
			next_state.origin_x       = req.start_x;
			next_state.origin_y       = req.start_y;
			next_state.step_limit     = req.step_count;
			next_state.active         = 1'b1;
		end else begin
			has_result      = 1'b1;
			result.run_done = 1'b1;
			if (state.active) begin
				if (steps >= state.step_limit) begin
					next_state.active  = 1'b0;
					result.steps_taken = steps;
				end else if (outside) begin
					next_state.active  = 1'b0;
					result.clipped     = 1'b1;
					result.steps_taken = steps;
				end else begin
					result.pixel_valid = 1'b1;
					result.pixel_x     = cx[cbrs_pkg::COORD_BITS-1:0];
					result.pixel_y     = cy[cbrs_pkg::COORD_BITS-1:0];
					if (err_sub < 0) begin
						next_state.minor_offset = state.minor_negative ?
							state.minor_offset - one : state.minor_offset + one;
						next_state.error_term   = err_sub +
							cbrs_pkg::err_t'({2'b00, state.major_delta});
					end else begin
						next_state.error_term   = err_sub;
					end
					next_state.major_offset = state.major_negative ?
						state.major_offset - one : state.major_offset + one;
					if (steps_next >= state.step_limit) begin
						next_state.active  = 1'b0;
						result.steps_taken = steps_next;
					end else begin
						result.run_done    = 1'b0;
					end
				end
			end
		end
	end

endmodule
